// ===== hdl/mrclm_pkg.sv =====
// shared codes, configuration defaults, inter-module structs and the crc-16 byte step
package mrclm_pkg;

   // operation codes on the request channel
   localparam logic [1:0] OP_WRITE   = 2'd0;
   localparam logic [1:0] OP_POLL    = 2'd1;
   localparam logic [1:0] OP_BYTE    = 2'd2;
   localparam logic [1:0] OP_TIMEOUT = 2'd3;

   // pending transaction kinds
   localparam logic [1:0] PEND_NONE  = 2'd0;
   localparam logic [1:0] PEND_WRITE = 2'd1;
   localparam logic [1:0] PEND_POLL  = 2'd2;

   // response beat kinds
   localparam logic KIND_TX      = 1'b0;
   localparam logic KIND_OUTCOME = 1'b1;

   // configuration register indexes
   localparam logic [1:0] CSR_SLAVE_ID   = 2'd0;
   localparam logic [1:0] CSR_COIL_COUNT = 2'd1;
   localparam logic [1:0] CSR_MISS_LIMIT = 2'd2;

   // configuration values after reset
   localparam logic [7:0] SLAVE_ID_RST   = 8'd6;
   localparam logic [7:0] COIL_COUNT_RST = 8'd8;
   localparam logic [7:0] MISS_LIMIT_RST = 8'd3;

   // frame constants
   localparam logic [7:0]  FUNC_WRITE_COIL = 8'h05;
   localparam logic [7:0]  FUNC_READ_COILS = 8'h01;
   localparam logic [7:0]  BYTE_COUNT_ONE  = 8'h01;
   localparam logic [7:0]  COIL_ON         = 8'hFF;
   localparam logic [7:0]  MISS_MAX        = 8'hFF;
   localparam logic [15:0] CRC_INIT        = 16'hFFFF;
   localparam logic [15:0] CRC_POLY        = 16'hA001;

   typedef struct packed {
      logic [7:0] slave_id;
      logic [7:0] coil_count;
      logic [7:0] miss_limit;
   } cfg_type;

   // frame sender control
   typedef struct packed {
      logic       start;
      logic       advance;
      logic       poll;
      logic [7:0] slave_id;
      logic [7:0] addr;
      logic       on;
      logic [7:0] coil_count;
   } tx_ctl_type;

   // frame sender status and current beat
   typedef struct packed {
      logic        busy;
      logic [7:0]  data;
      logic        last;
      logic [15:0] crc;
   } tx_stat_type;

   // item handed to the reply checker
   typedef struct packed {
      logic       valid;
      logic [1:0] op;
      logic [7:0] addr;
      logic       on;
      logic [7:0] rx;
   } rx_evt_type;

   // reply checker result and presence after this item
   typedef struct packed {
      logic       outcome;
      logic       ok;
      logic       online;
      logic [7:0] missed;
   } rx_stat_type;

   // one byte through crc-16, reflected polynomial
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ===== hdl/modbus_rtu_coil_link_master_top.sv =====
// top level: input register, configuration registers, frame sender, reply checker, output register
//
//   channel | direction | content
//   req_*   | in        | tuser: operation; tdata: coil_address, coil_value, rx_byte
//   rsp_*   | out       | tuser: kind; tlast: last; tdata: tx_byte, success, peer_online,
//           |           |        missed_polls
//   csr_*   | in        | write enable, register index, 8-bit write data
//
// a received byte or timeout is one item; a send command gives 8 request bytes, which
// the frame sender emits a byte a beat with a running crc.
// the input register takes the next beat while a result waits in the output register.
// reset is synchronous; it clears the pending transaction and sets the peer offline
// with the miss count at three. rsp_tready low holds both registers without loss.
module modbus_rtu_coil_link_master_top import mrclm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // coil_address[7:0], coil_value[8], rx_byte[16:9]
   input  logic [1:0]  req_tuser,   // operation[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // tx_byte[7:0], success[8], peer_online[9],
                                    // missed_polls[17:10]
   output logic        rsp_tuser,   // kind
   output logic        rsp_tlast,   // last
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   cfg_type     cfg_ff, cfg_in;
   logic        in_valid_ff, in_valid_in;
   logic [1:0]  in_op_ff;
   logic [7:0]  in_addr_ff;
   logic        in_on_ff;
   logic [7:0]  in_rx_ff;
   logic        req_beat;
   logic        out_free;
   logic        step;
   tx_ctl_type  tx_ctl;
   tx_stat_type tx_stat;
   rx_evt_type  rx_evt;
   rx_stat_type rx_stat;
   logic        load;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_kind_ff;
   logic [7:0]  rsp_byte_ff;
   logic        rsp_last_ff;
   logic        rsp_ok_ff;
   logic        rsp_online_ff;
   logic [7:0]  rsp_miss_ff;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SLAVE_ID:   cfg_in.slave_id   = csr_wdata;
            CSR_COIL_COUNT: cfg_in.coil_count = csr_wdata;
            CSR_MISS_LIMIT: cfg_in.miss_limit = csr_wdata;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slave_id   <= SLAVE_ID_RST;
         cfg_ff.coil_count <= COIL_COUNT_RST;
         cfg_ff.miss_limit <= MISS_LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // handshake control
   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign step        = in_valid_ff && !tx_stat.busy && out_free;
   assign req_tready  = !in_valid_ff || step;
   assign req_beat    = req_tvalid && req_tready;
   assign in_valid_in = req_beat ? 1'b1 : (step ? 1'b0 : in_valid_ff);

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         in_op_ff   <= req_tuser;
         in_addr_ff <= req_tdata[7:0];
         in_on_ff   <= req_tdata[8];
         in_rx_ff   <= req_tdata[16:9];
      end
   end

   // frame sender
   assign tx_ctl.start      = step && ((in_op_ff == OP_POLL) ||
                              ((in_op_ff == OP_WRITE) && (in_addr_ff < cfg_ff.coil_count)));
   assign tx_ctl.advance    = out_free && tx_stat.busy;
   assign tx_ctl.poll       = (in_op_ff == OP_POLL);
   assign tx_ctl.slave_id   = cfg_ff.slave_id;
   assign tx_ctl.addr       = in_addr_ff;
   assign tx_ctl.on         = in_on_ff;
   assign tx_ctl.coil_count = cfg_ff.coil_count;

   mrclm_tx u_tx (
      .clock (clock),
      .reset (reset),
      .ctl   (tx_ctl),
      .stat  (tx_stat)
   );

   // reply checker
   assign rx_evt.valid = step;
   assign rx_evt.op    = in_op_ff;
   assign rx_evt.addr  = in_addr_ff;
   assign rx_evt.on    = in_on_ff;
   assign rx_evt.rx    = in_rx_ff;

   mrclm_rx u_rx (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .evt       (rx_evt),
      .frame_crc (tx_stat.crc),
      .stat      (rx_stat)
   );

   // output register
   assign load         = tx_ctl.start || tx_ctl.advance || rx_stat.outcome;
   assign rsp_valid_in = load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_kind_ff   <= rx_stat.outcome ? KIND_OUTCOME : KIND_TX;
         rsp_byte_ff   <= rx_stat.outcome ? 8'h00 : tx_stat.data;
         rsp_last_ff   <= rx_stat.outcome || tx_stat.last;
         rsp_ok_ff     <= rx_stat.ok;
         rsp_online_ff <= rx_stat.online;
         rsp_miss_ff   <= rx_stat.missed;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {6'b000000, rsp_miss_ff, rsp_online_ff, rsp_ok_ff, rsp_byte_ff};

   // a frame in flight always has its current byte waiting in the output register
   a_busy_holds_beat: assert property (@(posedge clock) disable iff (reset)
      tx_stat.busy |-> rsp_valid_ff)
      else $error("frame sender busy with no beat in the output register");

   // outcome beats are single-beat, carry no transmit byte
   a_outcome_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == KIND_OUTCOME)) |-> (rsp_tlast && (rsp_tdata[7:0] == 8'h00)))
      else $error("outcome beat without last or with a transmit byte");

   // a clear miss count only follows a good poll, which sets the peer online
   a_miss_clear_online: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[17:10] == 8'h00)) |-> rsp_tdata[9])
      else $error("miss count clear while peer offline");

   // no item taken from the input register while a frame is being sent
   a_no_step_in_frame: assert property (@(posedge clock) disable iff (reset)
      (tx_stat.busy && !tx_stat.last) |=> !rx_stat.outcome)
      else $error("outcome produced in the middle of a request frame");

endmodule

// ===== hdl/mrclm_tx.sv =====
// request frame sender: one byte a beat, running crc appended as the last two bytes
module mrclm_tx import mrclm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  tx_ctl_type  ctl,
   output tx_stat_type stat
);

   localparam logic [2:0] CNT_CRC_LO = 3'd6;

   logic        busy_ff, busy_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [7:0]  sh_ff [0:4];
   logic [7:0]  sh_in [0:4];
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  data;
   logic        last;

   // beat selection and next state
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      crc_in  = crc_ff;
      data    = 8'h00;
      last    = 1'b0;
      for (int i = 0; i < 5; i++) begin
         sh_in[i] = sh_ff[i];
      end
      if (ctl.start) begin
         // first byte goes straight out, the remaining header bytes are queued
         data     = ctl.slave_id;
         busy_in  = 1'b1;
         cnt_in   = 3'd1;
         crc_in   = crc_feed(CRC_INIT, ctl.slave_id);
         sh_in[0] = ctl.poll ? FUNC_READ_COILS : FUNC_WRITE_COIL;
         sh_in[1] = 8'h00;
         sh_in[2] = ctl.poll ? 8'h00 : ctl.addr;
         sh_in[3] = (ctl.poll || !ctl.on) ? 8'h00 : COIL_ON;
         sh_in[4] = ctl.poll ? ctl.coil_count : 8'h00;
      end else if (ctl.advance) begin
         if (cnt_ff < CNT_CRC_LO) begin
            data   = sh_ff[0];
            crc_in = crc_feed(crc_ff, sh_ff[0]);
         end else if (cnt_ff == CNT_CRC_LO) begin
            data = crc_ff[7:0];
         end else begin
            data    = crc_ff[15:8];
            last    = 1'b1;
            busy_in = 1'b0;
         end
         for (int i = 0; i < 4; i++) begin
            sh_in[i] = sh_ff[i + 1];
         end
         cnt_in = cnt_ff + 3'd1;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= 3'd0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   // queued bytes and crc
   always_ff @(posedge clock) begin
      crc_ff <= crc_in;
      for (int i = 0; i < 5; i++) begin
         sh_ff[i] <= sh_in[i];
      end
   end

   assign stat.busy = busy_ff;
   assign stat.data = data;
   assign stat.last = last;
   assign stat.crc  = crc_ff;

endmodule

// ===== hdl/mrclm_rx.sv =====
// reply checker: echo or header compare, reply crc, outcome and peer presence tracking
module mrclm_rx import mrclm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  rx_evt_type  evt,
   input  logic [15:0] frame_crc,
   output rx_stat_type stat
);

   localparam logic [2:0] WRITE_CRC_POS = 3'd6;
   localparam logic [2:0] POLL_CRC_POS  = 3'd4;
   localparam logic [2:0] POLL_HDR_LEN  = 3'd3;

   logic [1:0]  pend_ff, pend_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  low_ff, low_in;
   logic        hm_ff, hm_in;
   logic        online_ff, online_in;
   logic [7:0]  miss_ff, miss_in;
   logic [7:0]  exp_id_ff, exp_id_in;
   logic [7:0]  exp_addr_ff, exp_addr_in;
   logic        exp_on_ff, exp_on_in;

   logic [7:0]  exp_byte;
   logic        is_write;
   logic        cmp_en;
   logic        hm_nx;
   logic [2:0]  crc_pos;
   logic [7:0]  miss_up;
   logic        online_fail;
   logic        reply_ok;
   logic        outcome;
   logic        ok;

   assign is_write = (pend_ff == PEND_WRITE);
   assign crc_pos  = is_write ? WRITE_CRC_POS : POLL_CRC_POS;
   assign cmp_en   = is_write || (cnt_ff < POLL_HDR_LEN);

   // expected reply byte at the current position
   always_comb begin
      exp_byte = 8'h00;
      if (is_write) begin
         case (cnt_ff)
            3'd0:    exp_byte = exp_id_ff;
            3'd1:    exp_byte = FUNC_WRITE_COIL;
            3'd3:    exp_byte = exp_addr_ff;
            3'd4:    exp_byte = exp_on_ff ? COIL_ON : 8'h00;
            3'd6:    exp_byte = frame_crc[7:0];
            3'd7:    exp_byte = frame_crc[15:8];
            default: exp_byte = 8'h00;
         endcase
      end else begin
         case (cnt_ff)
            3'd0:    exp_byte = exp_id_ff;
            3'd1:    exp_byte = FUNC_READ_COILS;
            3'd2:    exp_byte = BYTE_COUNT_ONE;
            default: exp_byte = 8'h00;
         endcase
      end
   end

   assign hm_nx    = hm_ff && !(cmp_en && (evt.rx != exp_byte));
   assign reply_ok = hm_nx && ({evt.rx, low_ff} == crc_ff);

   // failed poll: saturating miss count, offline once the limit is reached
   assign miss_up     = (miss_ff == MISS_MAX) ? miss_ff : miss_ff + 8'd1;
   assign online_fail = (miss_up >= cfg.miss_limit) ? 1'b0 : online_ff;

   // per-item state update
   always_comb begin
      pend_in     = pend_ff;
      cnt_in      = cnt_ff;
      crc_in      = crc_ff;
      low_in      = low_ff;
      hm_in       = hm_ff;
      online_in   = online_ff;
      miss_in     = miss_ff;
      exp_id_in   = exp_id_ff;
      exp_addr_in = exp_addr_ff;
      exp_on_in   = exp_on_ff;
      outcome     = 1'b0;
      ok          = 1'b0;
      if (evt.valid) begin
         unique case (evt.op)
            OP_WRITE: begin
               pend_in = PEND_NONE;
               if (evt.addr >= cfg.coil_count) begin
                  outcome = 1'b1;
               end else begin
                  pend_in     = PEND_WRITE;
                  cnt_in      = 3'd0;
                  crc_in      = CRC_INIT;
                  low_in      = 8'h00;
                  hm_in       = 1'b1;
                  exp_id_in   = cfg.slave_id;
                  exp_addr_in = evt.addr;
                  exp_on_in   = evt.on;
               end
            end
            OP_POLL: begin
               pend_in   = PEND_POLL;
               cnt_in    = 3'd0;
               crc_in    = CRC_INIT;
               low_in    = 8'h00;
               hm_in     = 1'b1;
               exp_id_in = cfg.slave_id;
            end
            OP_TIMEOUT: begin
               if (pend_ff != PEND_NONE) begin
                  if (pend_ff == PEND_POLL) begin
                     miss_in   = miss_up;
                     online_in = online_fail;
                  end
                  pend_in = PEND_NONE;
                  outcome = 1'b1;
               end
            end
            OP_BYTE: begin
               if (pend_ff != PEND_NONE) begin
                  hm_in = hm_nx;
                  if (cnt_ff < crc_pos) begin
                     crc_in = crc_feed(crc_ff, evt.rx);
                     cnt_in = cnt_ff + 3'd1;
                  end else if (cnt_ff == crc_pos) begin
                     low_in = evt.rx;
                     cnt_in = cnt_ff + 3'd1;
                  end else begin
                     // crc high byte closes the reply
                     outcome = 1'b1;
                     ok      = reply_ok;
                     pend_in = PEND_NONE;
                     cnt_in  = 3'd0;
                     if (pend_ff == PEND_POLL) begin
                        if (reply_ok) begin
                           online_in = 1'b1;
                           miss_in   = 8'h00;
                        end else begin
                           miss_in   = miss_up;
                           online_in = online_fail;
                        end
                     end
                  end
               end
            end
            default: begin
               pend_in = pend_ff;
            end
         endcase
      end
   end

   // control and tracked state
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff   <= PEND_NONE;
         cnt_ff    <= 3'd0;
         crc_ff    <= CRC_INIT;
         low_ff    <= 8'h00;
         hm_ff     <= 1'b1;
         online_ff <= 1'b0;
         miss_ff   <= MISS_LIMIT_RST;
      end else begin
         pend_ff   <= pend_in;
         cnt_ff    <= cnt_in;
         crc_ff    <= crc_in;
         low_ff    <= low_in;
         hm_ff     <= hm_in;
         online_ff <= online_in;
         miss_ff   <= miss_in;
      end
   end

   // expected reply bytes, valid once a request is sent
   always_ff @(posedge clock) begin
      exp_id_ff   <= exp_id_in;
      exp_addr_ff <= exp_addr_in;
      exp_on_ff   <= exp_on_in;
   end

   assign stat.outcome = outcome;
   assign stat.ok      = ok;
   assign stat.online  = online_in;
   assign stat.missed  = miss_in;

endmodule
